### src/nhlt_pkg.sv
// shared types and constants for the neighbor history list tracker
package nhlt_pkg;

    localparam int SLOT_W = 14;
    localparam int OUT_W  = 7;

    typedef enum logic [1:0] {
        REQ_UPDATE = 2'd0,
        REQ_PURGE  = 2'd1,
        REQ_REINIT = 2'd2,
        REQ_BAD    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        LIST_ABS = 2'd0,
        LIST_PRE = 2'd1,
        LIST_FIN = 2'd2,
        LIST_NONE = 2'd3
    } list_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_U_RD,
        ST_UNLINK,
        ST_APP_RD,
        ST_APP_WR1,
        ST_APP_WR2,
        ST_P_HEAD,
        ST_P_NODE,
        ST_P_AGE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic rebuild;
        logic rd_x;
        logic take_head;
        logic unlink;
        logic app_rd;
        logic app_wr1;
        logic app_wr2;
        logic head_rd;
        logic next_list;
        logic inc_purged;
        logic capture;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic bad;
        logic list_empty;
        logic head_hit;
        logic too_old;
        logic list_fin;
        logic out_busy;
    } status_t;

endpackage

### src/neighbor_history_list_tracker.sv
// top level of the neighbor history list tracker
//
// input channel: in_valid/in_ready carry one request item (update, purge or
// reinitialise); output channel: out_valid/out_ready carry one result item per
// request with the three list sizes, the purge count, the sticky full-rank
// flag and the bad request flag.
// cfg_wr_en/cfg_wr_data write num_nodes (saturated to 1..MAX_NODES) and
// rebuild the initial lists in the same cycle.
// one item is worked at a time through the shared link memory ports:
//   bad request: no list changes; reinitialise: rebuilds the initial lists
//   update: dependent reads and writes of the link memories
//   purge: walks the present list, then the finished list, from the head,
//   moving each node that is too old to absent
// a result waits in the output register while the receiver stalls; the next
// item is still taken, and its result is held back until the register is free.
// after reset all nodes are absent, num_nodes is MAX_NODES capped at 64 and the flag is clear;
// link memory entries carry valid bits, so no clearing pass is needed.
module neighbor_history_list_tracker
    import nhlt_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [5:0]  node_index,
    input  logic [15:0] rx_slot,
    input  logic        full_rank,
    input  logic        shutdown,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  absent_count,
    output logic [6:0]  present_count,
    output logic [6:0]  finished_count,
    output logic [6:0]  purged_count,
    output logic        full_rank_seen,
    output logic        bad_request
);

    cmd_t    cmd;
    status_t sts;

    nhlt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nhlt_dp #(.MAX_NODES(MAX_NODES)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .req_type       (req_type),
        .node_index     (node_index),
        .rx_slot        (rx_slot),
        .full_rank      (full_rank),
        .shutdown       (shutdown),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .absent_count   (absent_count),
        .present_count  (present_count),
        .finished_count (finished_count),
        .purged_count   (purged_count),
        .full_rank_seen (full_rank_seen),
        .bad_request    (bad_request)
    );

endmodule

### src/nhlt_ram.sv
// generic single write port ram with registered read
module nhlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/nhlt_ctrl.sv
// controller state machine sequencing list operations
module nhlt_ctrl
    import nhlt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.bad)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    case (sts.req)
                        REQ_UPDATE: state_next = ST_U_RD;
                        REQ_PURGE:  state_next = ST_P_HEAD;
                        REQ_REINIT:
                        begin
                            cmd.rebuild = 1'b1;
                            state_next  = ST_DONE;
                        end
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_U_RD:
            begin
                cmd.rd_x   = 1'b1;
                state_next = ST_UNLINK;
            end
            ST_UNLINK:
            begin
                cmd.unlink = 1'b1;
                state_next = ST_APP_RD;
            end
            ST_APP_RD:
            begin
                cmd.app_rd = 1'b1;
                state_next = ST_APP_WR1;
            end
            ST_APP_WR1:
            begin
                cmd.app_wr1 = 1'b1;
                state_next  = ST_APP_WR2;
            end
            ST_APP_WR2:
            begin
                cmd.app_wr2 = 1'b1;
                if (sts.req == REQ_PURGE)
                begin
                    cmd.inc_purged = 1'b1;
                    state_next     = ST_P_HEAD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_P_HEAD:
            begin
                if (sts.list_empty)
                begin
                    if (sts.list_fin)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.next_list = 1'b1;
                    end
                end
                else
                begin
                    cmd.head_rd = 1'b1;
                    state_next  = ST_P_NODE;
                end
            end
            ST_P_NODE:
            begin
                if (sts.head_hit)
                begin
                    cmd.next_list = !sts.list_fin;
                    state_next    = sts.list_fin ? ST_DONE : ST_P_HEAD;
                end
                else
                begin
                    cmd.rd_x      = 1'b1;
                    cmd.take_head = 1'b1;
                    state_next    = ST_P_AGE;
                end
            end
            ST_P_AGE:
            begin
                if (sts.too_old)
                begin
                    state_next = ST_UNLINK;
                end
                else
                begin
                    cmd.next_list = !sts.list_fin;
                    state_next    = sts.list_fin ? ST_DONE : ST_P_HEAD;
                end
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### src/nhlt_dp.sv
// datapath with link, tag and slot memories and list counters
module nhlt_dp
    import nhlt_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             sts,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data,
    input  logic [1:0]          req_type,
    input  logic [5:0]          node_index,
    input  logic [15:0]         rx_slot,
    input  logic                full_rank,
    input  logic                shutdown,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [OUT_W-1:0]    absent_count,
    output logic [OUT_W-1:0]    present_count,
    output logic [OUT_W-1:0]    finished_count,
    output logic [OUT_W-1:0]    purged_count,
    output logic                full_rank_seen,
    output logic                bad_request
);

    localparam int LD = MAX_NODES + 3;
    localparam int LW = $clog2(LD);
    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int N_RST = (MAX_NODES < 64) ? MAX_NODES : 64;
    localparam logic [LW-1:0] HA = LW'(MAX_NODES);

    logic [6:0]        nn_reg;
    req_t              req_reg;
    logic [LW-1:0]     x_reg;
    logic [15:0]       slot_reg;
    logic              full_reg;
    list_t             tgt_reg;
    list_t             list_reg;
    logic              bad_reg;
    logic              flag_reg;
    logic [CW-1:0]     size_reg [3];
    logic [CW-1:0]     purged_reg;
    logic [LD-1:0]     prev_vld_reg, next_vld_reg;
    logic [MAX_NODES-1:0] tag_vld_reg;
    logic [LW-1:0]     prev_ra_reg, next_ra_reg;
    logic              prev_v_reg, next_v_reg, tag_v_reg;

    logic [LW-1:0]     prev_q, next_q, prev_rd, next_rd, x_addr, init_prev, init_next;
    logic [1:0]        tag_q;
    list_t             tag_eff;
    logic [SLOT_W-1:0] slot_q, age;
    logic [8:0]        window;
    logic              prev_we, next_we, prev_re, next_re;
    logic [LW-1:0]     prev_wa, prev_wd, next_wa, next_wd, prev_raddr, next_raddr;
    logic [6:0]        cfg_sat;

    function automatic logic [LW-1:0] head_of(list_t t);
        return HA + LW'(t);
    endfunction

    // unwritten link entries read as the initial chain
    always_comb
    begin
        init_prev = prev_ra_reg;
        if (32'(prev_ra_reg) < MAX_NODES)
        begin
            init_prev = (prev_ra_reg == '0) ? HA : prev_ra_reg - LW'(1);
        end
        else if (prev_ra_reg == HA)
        begin
            init_prev = LW'(nn_reg) - LW'(1);
        end
        init_next = next_ra_reg;
        if (32'(next_ra_reg) < MAX_NODES)
        begin
            init_next = (next_ra_reg + LW'(1) == LW'(nn_reg)) ? HA : next_ra_reg + LW'(1);
        end
        else if (next_ra_reg == HA)
        begin
            init_next = '0;
        end
    end

    assign prev_rd = prev_v_reg ? prev_q : init_prev;
    assign next_rd = next_v_reg ? next_q : init_next;
    assign tag_eff = tag_v_reg ? list_t'(tag_q) : LIST_ABS;
    assign x_addr  = cmd.take_head ? next_rd : x_reg;

    always_comb
    begin
        prev_re    = cmd.rd_x || cmd.app_rd;
        prev_raddr = cmd.app_rd ? head_of(tgt_reg) : x_addr;
        next_re    = cmd.rd_x || cmd.head_rd;
        next_raddr = cmd.head_rd ? head_of(list_reg) : x_addr;
        prev_we = cmd.unlink || cmd.app_wr1 || cmd.app_wr2;
        next_we = prev_we;
        prev_wa = next_rd;
        prev_wd = prev_rd;
        next_wa = prev_rd;
        next_wd = next_rd;
        if (cmd.app_wr1)
        begin
            prev_wa = x_reg;
            prev_wd = prev_rd;
            next_wa = prev_rd;
            next_wd = x_reg;
        end
        else if (cmd.app_wr2)
        begin
            prev_wa = head_of(tgt_reg);
            prev_wd = x_reg;
            next_wa = x_reg;
            next_wd = head_of(tgt_reg);
        end
    end

    nhlt_ram #(.WIDTH(LW), .DEPTH(LD)) u_prev (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_wa),
        .wdata (prev_wd),
        .re    (prev_re),
        .raddr (prev_raddr),
        .rdata (prev_q)
    );

    nhlt_ram #(.WIDTH(LW), .DEPTH(LD)) u_next (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_wa),
        .wdata (next_wd),
        .re    (next_re),
        .raddr (next_raddr),
        .rdata (next_q)
    );

    nhlt_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_tag (
        .clk   (clk),
        .we    (cmd.app_wr1),
        .waddr (x_reg[NW-1:0]),
        .wdata (tgt_reg),
        .re    (cmd.rd_x),
        .raddr (x_addr[NW-1:0]),
        .rdata (tag_q)
    );

    nhlt_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_NODES)) u_slot (
        .clk   (clk),
        .we    (cmd.rd_x && !cmd.take_head),
        .waddr (x_reg[NW-1:0]),
        .wdata (slot_reg[SLOT_W-1:0]),
        .re    (cmd.take_head),
        .raddr (x_addr[NW-1:0]),
        .rdata (slot_q)
    );

    assign age    = slot_reg[SLOT_W-1:0] - slot_q;
    assign window = (list_reg == LIST_PRE) ? 9'(nn_reg) + {1'b0, nn_reg, 1'b0} : 9'(nn_reg);

    assign cfg_sat = (cfg_wr_data == '0) ? 7'd1 :
                     (32'(cfg_wr_data) > MAX_NODES) ? 7'(MAX_NODES) : cfg_wr_data;

    always_comb
    begin
        sts            = '0;
        sts.req        = req_reg;
        sts.bad        = bad_reg;
        sts.list_empty = (size_reg[list_reg] == '0);
        sts.head_hit   = (32'(next_rd) >= MAX_NODES);
        sts.too_old    = (age > SLOT_W'(window));
        sts.list_fin   = (list_reg == LIST_FIN);
        sts.out_busy   = out_valid && !out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req_t'(req_type);
            x_reg    <= LW'(node_index);
            slot_reg <= rx_slot;
            full_reg <= full_rank;
            bad_reg  <= (req_t'(req_type) == REQ_BAD) ||
                        ((req_t'(req_type) == REQ_UPDATE) &&
                         (({1'b0, node_index} >= nn_reg) || (32'(node_index) >= MAX_NODES)));
            if (req_t'(req_type) == REQ_PURGE || shutdown)
            begin
                tgt_reg <= LIST_ABS;
            end
            else
            begin
                tgt_reg <= full_rank ? LIST_FIN : LIST_PRE;
            end
        end
        else if (cmd.take_head)
        begin
            x_reg <= next_rd;
        end
        if (prev_re)
        begin
            prev_ra_reg <= prev_raddr;
            prev_v_reg  <= prev_vld_reg[prev_raddr];
        end
        if (next_re)
        begin
            next_ra_reg <= next_raddr;
            next_v_reg  <= next_vld_reg[next_raddr];
        end
        if (cmd.rd_x)
        begin
            tag_v_reg <= tag_vld_reg[x_addr[NW-1:0]];
        end
        if (cmd.capture)
        begin
            absent_count   <= OUT_W'(size_reg[LIST_ABS]);
            present_count  <= OUT_W'(size_reg[LIST_PRE]);
            finished_count <= OUT_W'(size_reg[LIST_FIN]);
            purged_count   <= OUT_W'(purged_reg);
            full_rank_seen <= flag_reg;
            bad_request    <= bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nn_reg       <= 7'(N_RST);
            list_reg     <= LIST_PRE;
            flag_reg     <= 1'b0;
            size_reg[0]  <= CW'(N_RST);
            size_reg[1]  <= '0;
            size_reg[2]  <= '0;
            purged_reg   <= '0;
            prev_vld_reg <= '0;
            next_vld_reg <= '0;
            tag_vld_reg  <= '0;
            out_valid    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en || cmd.rebuild)
            begin
                if (cfg_wr_en)
                begin
                    nn_reg      <= cfg_sat;
                    size_reg[0] <= CW'(cfg_sat);
                end
                else
                begin
                    size_reg[0] <= CW'(nn_reg);
                end
                size_reg[1]  <= '0;
                size_reg[2]  <= '0;
                flag_reg     <= 1'b0;
                prev_vld_reg <= '0;
                next_vld_reg <= '0;
                tag_vld_reg  <= '0;
            end
            else
            begin
                if (cmd.rd_x && !cmd.take_head && full_reg)
                begin
                    flag_reg <= 1'b1;
                end
                if (prev_we)
                begin
                    prev_vld_reg[prev_wa] <= 1'b1;
                end
                if (next_we)
                begin
                    next_vld_reg[next_wa] <= 1'b1;
                end
                if (cmd.app_wr1)
                begin
                    tag_vld_reg[x_reg[NW-1:0]] <= 1'b1;
                    size_reg[tgt_reg] <= size_reg[tgt_reg] + CW'(1);
                end
                if (cmd.unlink && size_reg[tag_eff] != '0)
                begin
                    size_reg[tag_eff] <= size_reg[tag_eff] - CW'(1);
                end
            end
            if (cmd.load)
            begin
                list_reg   <= LIST_PRE;
                purged_reg <= '0;
            end
            else
            begin
                if (cmd.next_list)
                begin
                    list_reg <= LIST_FIN;
                end
                if (cmd.inc_purged)
                begin
                    purged_reg <= purged_reg + CW'(1);
                end
            end
            if (cmd.capture)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

endmodule

### src/nhlt_checker.sv
// port level checks for the neighbor history list tracker
module nhlt_checker #(
    parameter int MAX_NODES = 64
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] absent_count,
    input logic [6:0] present_count,
    input logic [6:0] finished_count,
    input logic [6:0] purged_count,
    input logic       bad_request
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(absent_count))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while busy");

    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (9'(absent_count) + 9'(present_count) + 9'(finished_count))
                      <= 9'(MAX_NODES))
        else $error("list sizes exceed node count");

    a_bad_no_purge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_request |-> purged_count == '0)
        else $error("bad request reports purged nodes");

endmodule

bind neighbor_history_list_tracker nhlt_checker #(.MAX_NODES(MAX_NODES)) u_nhlt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .absent_count   (absent_count),
    .present_count  (present_count),
    .finished_count (finished_count),
    .purged_count   (purged_count),
    .bad_request    (bad_request)
);

### sim/neighbor_history_list_tracker_chk.sv
// checker: watches both channels, tracks the neighbor lists and compares results
module neighbor_history_list_tracker_chk
    import nhlt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [5:0]  node_index,
    input  logic [15:0] rx_slot,
    input  logic        full_rank,
    input  logic        shutdown,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [6:0]  absent_count,
    input  logic [6:0]  present_count,
    input  logic [6:0]  finished_count,
    input  logic [6:0]  purged_count,
    input  logic        full_rank_seen,
    input  logic        bad_request,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = 64;
    localparam int DEPTH = NODES + 3;

    typedef struct packed {
        logic [6:0] absent;
        logic [6:0] present;
        logic [6:0] finished;
        logic [6:0] purged;
        logic       rank;
        logic       bad;
    } tally_t;

    logic [6:0]  prev_link [DEPTH];
    logic [6:0]  next_link [DEPTH];
    list_t       member_of [NODES];
    logic [13:0] heard_slot [NODES];
    logic [6:0]  list_len [3];
    logic        rank_seen;
    logic [6:0]  node_limit;
    tally_t      tally_q [$];

    function automatic logic [6:0] clip_link(logic [6:0] x);
        return (x < DEPTH) ? x : 7'd0;
    endfunction

    task automatic rebuild_chains();
        for (int i = 0; i < DEPTH; i++)
        begin
            prev_link[i] = '0;
            next_link[i] = '0;
        end
        for (int i = 0; i < NODES; i++)
            member_of[i] = LIST_ABS;
        for (int i = 0; i < node_limit; i++)
        begin
            prev_link[i] = (i == 0) ? 7'(NODES + LIST_ABS) : 7'(i - 1);
            next_link[i] = (i + 1 == node_limit) ? 7'(NODES + LIST_ABS) : 7'(i + 1);
        end
        next_link[NODES + LIST_ABS] = '0;
        prev_link[NODES + LIST_ABS] = 7'(node_limit - 1);
        for (int h = NODES + LIST_PRE; h <= NODES + LIST_FIN; h++)
        begin
            next_link[h] = 7'(h);
            prev_link[h] = 7'(h);
        end
        list_len[LIST_ABS] = node_limit;
        list_len[LIST_PRE] = '0;
        list_len[LIST_FIN] = '0;
        rank_seen = 1'b0;
    endtask

    function automatic void detach_node(int n);
        int t;
        logic [6:0] p;
        logic [6:0] q;
        t = int'(member_of[n]) % 3;
        p = clip_link(prev_link[n]);
        q = clip_link(next_link[n]);
        next_link[p] = q;
        prev_link[q] = p;
        if (list_len[t] > 0)
            list_len[t]--;
    endfunction

    function automatic void attach_tail(int n, list_t t);
        int h;
        logic [6:0] p;
        h = NODES + int'(t);
        p = clip_link(prev_link[h]);
        prev_link[n] = p;
        next_link[n] = 7'(h);
        next_link[p] = 7'(n);
        prev_link[h] = 7'(n);
        member_of[n] = t;
        list_len[t]++;
    endfunction

    function automatic int drop_stale(list_t t, logic [15:0] now, int window);
        int moved;
        int n;
        logic [13:0] age;
        moved = 0;
        while (list_len[t] > 0)
        begin
            n = clip_link(next_link[NODES + int'(t)]);
            if (n >= NODES)
                break;
            age = now[13:0] - heard_slot[n];
            if (age <= window)
                break;
            detach_node(n);
            attach_tail(n, LIST_ABS);
            moved++;
        end
        return moved;
    endfunction

    task automatic predict_request(req_t req, int node, logic [15:0] slot, logic full,
                                   logic off);
        tally_t r;
        int moved;
        moved = 0;
        r = '0;
        case (req)
            REQ_UPDATE:
                if (node >= node_limit)
                    r.bad = 1'b1;
                else
                begin
                    heard_slot[node] = slot[13:0];
                    if (full)
                        rank_seen = 1'b1;
                    detach_node(node);
                    if (off)
                        attach_tail(node, LIST_ABS);
                    else if (full)
                        attach_tail(node, LIST_FIN);
                    else
                        attach_tail(node, LIST_PRE);
                end
            REQ_PURGE:
            begin
                moved = drop_stale(LIST_PRE, slot, 3 * node_limit);
                moved += drop_stale(LIST_FIN, slot, node_limit);
            end
            REQ_REINIT:
                rebuild_chains();
            default:
                r.bad = 1'b1;
        endcase
        r.absent   = list_len[LIST_ABS];
        r.present  = list_len[LIST_PRE];
        r.finished = list_len[LIST_FIN];
        r.purged   = 7'(moved);
        r.rank     = rank_seen;
        tally_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tally_t got;
        tally_t want;
        if (!rst_n)
        begin
            node_limit = 7'd64;
            for (int i = 0; i < NODES; i++)
                heard_slot[i] = '0;
            rebuild_chains();
            tally_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{absent_count, present_count, finished_count, purged_count,
                        full_rank_seen, bad_request};
                if (tally_q.size() == 0)
                begin
                    $display("%t unexpected item: expected none actual %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = tally_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%t item mismatch: expected %h actual %h",
                                 $time, want, got);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en)
            begin
                node_limit = (cfg_wr_data == 0) ? 7'd1 :
                             (cfg_wr_data > NODES) ? 7'(NODES) : cfg_wr_data;
                rebuild_chains();
            end
            if (in_valid && in_ready)
                predict_request(req_t'(req_type), node_index, rx_slot,
                                full_rank, shutdown);
        end
        pending_count = tally_q.size();
    end
endmodule

### sim/neighbor_history_list_tracker_tb.sv
// testbench top: stimulus, idling phases and verdict for the list tracker
module neighbor_history_list_tracker_tb;
    import nhlt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = REQ_UPDATE;
    logic [5:0]  node_index = '0;
    logic [15:0] rx_slot = '0;
    logic        full_rank = 1'b0;
    logic        shutdown = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [6:0]  absent_count;
    logic [6:0]  present_count;
    logic [6:0]  finished_count;
    logic [6:0]  purged_count;
    logic        full_rank_seen;
    logic        bad_request;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          cycle_count = 0;
    int          node_cap = 64;
    logic [15:0] now_slot = '0;

    always #4 clk = ~clk;

    neighbor_history_list_tracker u_top (.*);
    neighbor_history_list_tracker_chk u_chk (.*);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycle_count > 2000000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_request(req_t req, logic [5:0] node, logic [15:0] slot,
                                logic full, logic off);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        node_index <= node;
        rx_slot <= slot;
        full_rank <= full;
        shutdown <= off;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic set_node_limit(logic [6:0] v);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        node_cap = (v == 0) ? 1 : (v > 64) ? 64 : v;
        @(posedge clk);
    endtask

    task automatic random_burst(int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            now_slot += 16'($urandom_range(3 * node_cap));
            if (pick < 65)
                send_request(REQ_UPDATE, 6'($urandom_range(node_cap - 1)),
                             now_slot - 16'($urandom_range(4 * node_cap)),
                             1'($urandom), ($urandom_range(5) == 0));
            else if (pick < 88)
                send_request(REQ_PURGE, 6'($urandom), now_slot, 1'($urandom), 1'($urandom));
            else if (pick < 92)
                send_request(REQ_REINIT, 6'($urandom), 16'($urandom), 1'($urandom),
                             1'($urandom));
            else if (pick < 96)
                send_request(REQ_BAD, 6'($urandom), 16'($urandom), 1'($urandom),
                             1'($urandom));
            else
                send_request(REQ_UPDATE, 6'($urandom), 16'($urandom), 1'($urandom),
                             1'($urandom));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, each request, bad nodes and wrap of the age
        send_request(REQ_UPDATE, 6'd0, 16'hFFFF, 1'b0, 1'b0);
        send_request(REQ_UPDATE, 6'd63, 16'h0000, 1'b1, 1'b0);
        send_request(REQ_UPDATE, 6'd5, 16'h3FFF, 1'b1, 1'b1);
        send_request(REQ_UPDATE, 6'd7, 16'hC000, 1'b0, 1'b0);
        send_request(REQ_UPDATE, 6'd7, 16'h0010, 1'b0, 1'b0);
        send_request(REQ_PURGE, 6'd0, 16'h0040, 1'b0, 1'b0);
        send_request(REQ_PURGE, 6'd63, 16'h4100, 1'b1, 1'b1);
        send_request(REQ_BAD, 6'd63, 16'hFFFF, 1'b1, 1'b1);
        send_request(REQ_REINIT, 6'd0, 16'd0, 1'b0, 1'b0);
        set_node_limit(7'd0);
        send_request(REQ_UPDATE, 6'd1, 16'd3, 1'b0, 1'b0);
        send_request(REQ_UPDATE, 6'd0, 16'd3, 1'b0, 1'b0);
        send_request(REQ_PURGE, 6'd0, 16'd7, 1'b0, 1'b0);
        set_node_limit(7'd127);
        send_request(REQ_UPDATE, 6'd63, 16'd100, 1'b0, 1'b0);
        send_request(REQ_PURGE, 6'd0, 16'd100, 1'b0, 1'b0);
        // hold off until every result is back
        drain_results();
        set_node_limit(7'd4);
        random_burst(90);
        send_idle_pct = 76;
        set_node_limit(7'd64);
        random_burst(110);
        send_idle_pct = 0;
        recv_stall_pct = 76;
        set_node_limit(7'd1);
        random_burst(60);
        set_node_limit(7'd17);
        send_idle_pct = 38;
        recv_stall_pct = 38;
        random_burst(110);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_node_limit(7'd9);
        random_burst(160);
        drain_results();
        if (fail_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### filelist.f
src/nhlt_pkg.sv
src/nhlt_ram.sv
src/nhlt_ctrl.sv
src/nhlt_dp.sv
src/neighbor_history_list_tracker.sv
src/nhlt_checker.sv
sim/neighbor_history_list_tracker_chk.sv
sim/neighbor_history_list_tracker_tb.sv
